### rtl/ptpsrv_pkg.sv
// ----------------------------------------------------------------------------
// ptpsrv_pkg
// Shared widths, codes and types for the PTP delay/offset/rate servo.
// ----------------------------------------------------------------------------
package ptpsrv_pkg;

  // port widths fixed by the interface
  localparam int IO_STAMP_W = 64;
  localparam int CMD_W      = 2;
  localparam int RATIO_W    = 32;

  // internal timestamp width and ratio fraction bits
  localparam int STAMP_WIDTH     = 64;
  localparam int RATIO_FRAC_BITS = 28;

  // dividend: stamp difference followed by the fraction bits
  localparam int DIV_W = STAMP_WIDTH + RATIO_FRAC_BITS;
  localparam int CNT_W = $clog2(DIV_W + 1);

  // a quotient bit at or above this weight means q >= 16 or no fit in 32 bits
  localparam int SAT_BIT = (RATIO_FRAC_BITS + 4 < RATIO_W) ? RATIO_FRAC_BITS + 4 : RATIO_W;

  localparam logic [CNT_W-1:0] RATIO_STEPS = CNT_W'(DIV_W);

  typedef logic [STAMP_WIDTH-1:0] stamp_t;
  typedef logic [STAMP_WIDTH:0]   sum_t;
  typedef logic [RATIO_W-1:0]     ratio_t;

  localparam ratio_t RATIO_ONE =
    {{(RATIO_W-RATIO_FRAC_BITS-1){1'b0}}, 1'b1, {RATIO_FRAC_BITS{1'b0}}};
  localparam ratio_t RATIO_MAX = '1;

  // floor(x / 10) = (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x
  localparam ratio_t RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int     RECIP_SHIFT = 35;

  // commands
  localparam logic [CMD_W-1:0] CMD_RATE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SYNC  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELAY = 2'd2;

  typedef enum logic [1:0] {
    EV_FIRST  = 2'd0,
    EV_RATIO  = 2'd1,
    EV_ORIGIN = 2'd2,
    EV_DELAY  = 2'd3
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RATIO_DIV,
    ST_SMOOTH_PREP,
    ST_SMOOTH_DIV,
    ST_SUM,
    ST_DIFF,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
  } div_ctl_t;

endpackage

### rtl/ptpsrv_div.sv
// ----------------------------------------------------------------------------
// ptpsrv_div
// Restoring divider, one quotient bit per cycle. The dividend is taken
// left-aligned; 'steps' sets how many of its top bits are consumed.
// ----------------------------------------------------------------------------
module ptpsrv_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ptpsrv_pkg::div_ctl_t            ctl,
  input  logic [ptpsrv_pkg::DIV_W-1:0]    num,
  input  ptpsrv_pkg::stamp_t              den,
  output logic                            done,
  output logic [ptpsrv_pkg::DIV_W-1:0]    quo
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [ptpsrv_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [ptpsrv_pkg::DIV_W-1:0]        num_r, num_nxt;
  logic [ptpsrv_pkg::DIV_W-1:0]        quo_r, quo_nxt;
  ptpsrv_pkg::stamp_t                  den_r, den_nxt;
  ptpsrv_pkg::stamp_t                  rem_r, rem_nxt;
  ptpsrv_pkg::sum_t                    trial;
  ptpsrv_pkg::sum_t                    trial_sub;
  logic                                ge;

  always_comb begin
    trial     = {rem_r, num_r[ptpsrv_pkg::DIV_W-1]};
    trial_sub = trial - {1'b0, den_r};
    ge        = (trial >= {1'b0, den_r});

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;

    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ctl.steps;
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? trial_sub[ptpsrv_pkg::STAMP_WIDTH-1:0]
                   : trial[ptpsrv_pkg::STAMP_WIDTH-1:0];
      num_nxt = {num_r[ptpsrv_pkg::DIV_W-2:0], 1'b0};
      quo_nxt = {quo_r[ptpsrv_pkg::DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ptpsrv_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### rtl/ptp_delay_offset_rate_servo.sv
// ----------------------------------------------------------------------------
// ptp_delay_offset_rate_servo
// PTP slave servo: smoothed rate ratio, line delay and clock offset.
// ----------------------------------------------------------------------------
// One word in, one word out (command 3 is swallowed with no result). Words
// are handled one at a time. A sync follow-up or the first rate sample of a
// pair goes from decode straight to delivery; a delay response passes
// through a sum and a difference state for the delay and again for the
// offset. The second rate sample of a pair waits on the restoring divider,
// which produces one quotient bit of the Q4.28 ratio a cycle; the tenth of
// the smoothing step comes from a reciprocal multiply. A finished result
// waits in the deliver state until the output register is free. A new word
// may be taken while the previous result still waits at the output.
module ptp_delay_offset_rate_servo (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ptpsrv_pkg::CMD_W-1:0]        in_command,
  input  logic [ptpsrv_pkg::IO_STAMP_W-1:0]   in_master_stamp,
  input  logic [ptpsrv_pkg::IO_STAMP_W-1:0]   in_local_rx_stamp,
  input  logic [ptpsrv_pkg::IO_STAMP_W-1:0]   in_local_tx_stamp,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_event_kind,
  output logic [ptpsrv_pkg::RATIO_W-1:0]      out_freq_ratio,
  output logic [ptpsrv_pkg::IO_STAMP_W-1:0]   out_delay_magnitude,
  output logic                                out_delay_negative,
  output logic [ptpsrv_pkg::IO_STAMP_W-1:0]   out_offset_magnitude,
  output logic                                out_offset_negative
);

  ptpsrv_pkg::state_t       state_r, state_nxt;
  logic [ptpsrv_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  ptpsrv_pkg::stamp_t       ms_r, ms_nxt;
  ptpsrv_pkg::stamp_t       rx_r, rx_nxt;
  ptpsrv_pkg::stamp_t       tx_r, tx_nxt;
  ptpsrv_pkg::stamp_t       first_ms_r, first_ms_nxt;
  ptpsrv_pkg::stamp_t       first_rx_r, first_rx_nxt;
  logic                     have_first_r, have_first_nxt;
  ptpsrv_pkg::stamp_t       origin_r, origin_nxt;
  ptpsrv_pkg::ratio_t       ratio_r, ratio_nxt;
  ptpsrv_pkg::stamp_t       dly_mag_r, dly_mag_nxt;
  logic                     dly_neg_r, dly_neg_nxt;
  ptpsrv_pkg::stamp_t       ofs_mag_r, ofs_mag_nxt;
  logic                     ofs_neg_r, ofs_neg_nxt;
  logic                     den_zero_r, den_zero_nxt;
  ptpsrv_pkg::ratio_t       meas_r, meas_nxt;
  logic                     sneg_r, sneg_nxt;
  logic                     phase_r, phase_nxt;
  ptpsrv_pkg::sum_t         sa_r, sa_nxt;
  ptpsrv_pkg::sum_t         sb_r, sb_nxt;
  ptpsrv_pkg::event_kind_t  kind_r, kind_nxt;

  logic                     out_valid_r, out_valid_nxt;
  ptpsrv_pkg::event_kind_t  out_kind_r, out_kind_nxt;
  ptpsrv_pkg::ratio_t       out_ratio_r, out_ratio_nxt;
  ptpsrv_pkg::stamp_t       out_dly_mag_r, out_dly_mag_nxt;
  logic                     out_dly_neg_r, out_dly_neg_nxt;
  ptpsrv_pkg::stamp_t       out_ofs_mag_r, out_ofs_mag_nxt;
  logic                     out_ofs_neg_r, out_ofs_neg_nxt;

  ptpsrv_pkg::div_ctl_t             div_ctl;
  logic [ptpsrv_pkg::DIV_W-1:0]     div_num;
  ptpsrv_pkg::stamp_t               div_den;
  logic                             div_done;
  logic [ptpsrv_pkg::DIV_W-1:0]     div_quo;

  ptpsrv_pkg::stamp_t       dm, dl;
  ptpsrv_pkg::stamp_t       op_a, op_b, op_c, op_d;
  ptpsrv_pkg::sum_t         diff_hi, diff_lo, diff;
  logic                     greater;
  logic                     ratio_sat;
  logic [2*ptpsrv_pkg::RATIO_W-1:0] recip_prod;
  ptpsrv_pkg::ratio_t       step;

  ptpsrv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    dm = ms_r - first_ms_r;
    dl = rx_r - first_rx_r;

    ratio_sat = den_zero_r | (|div_quo[ptpsrv_pkg::DIV_W-1:ptpsrv_pkg::SAT_BIT]);

    // meas_r holds |measured - ratio| once the smoothing step starts
    recip_prod = {{ptpsrv_pkg::RATIO_W{1'b0}}, meas_r} *
                 {{ptpsrv_pkg::RATIO_W{1'b0}}, ptpsrv_pkg::RECIP_TEN};
    step       = ptpsrv_pkg::ratio_t'(recip_prod >> ptpsrv_pkg::RECIP_SHIFT);

    // delay: (t4 + t2) - (t3 + t1); offset: (t2 + t3) - (t1 + t4)
    if (!phase_r) begin
      op_a = ms_r; op_b = rx_r; op_c = tx_r; op_d = origin_r;
    end else begin
      op_a = rx_r; op_b = tx_r; op_c = origin_r; op_d = ms_r;
    end

    greater = (sa_r > sb_r);
    diff_hi = greater ? sa_r : sb_r;
    diff_lo = greater ? sb_r : sa_r;
    diff    = diff_hi - diff_lo;

    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    ms_nxt          = ms_r;
    rx_nxt          = rx_r;
    tx_nxt          = tx_r;
    first_ms_nxt    = first_ms_r;
    first_rx_nxt    = first_rx_r;
    have_first_nxt  = have_first_r;
    origin_nxt      = origin_r;
    ratio_nxt       = ratio_r;
    dly_mag_nxt     = dly_mag_r;
    dly_neg_nxt     = dly_neg_r;
    ofs_mag_nxt     = ofs_mag_r;
    ofs_neg_nxt     = ofs_neg_r;
    den_zero_nxt    = den_zero_r;
    meas_nxt        = meas_r;
    sneg_nxt        = sneg_r;
    phase_nxt       = phase_r;
    sa_nxt          = sa_r;
    sb_nxt          = sb_r;
    kind_nxt        = kind_r;

    out_valid_nxt   = out_valid_r & out_stall;
    out_kind_nxt    = out_kind_r;
    out_ratio_nxt   = out_ratio_r;
    out_dly_mag_nxt = out_dly_mag_r;
    out_dly_neg_nxt = out_dly_neg_r;
    out_ofs_mag_nxt = out_ofs_mag_r;
    out_ofs_neg_nxt = out_ofs_neg_r;

    div_ctl.start = 1'b0;
    div_ctl.steps = ptpsrv_pkg::RATIO_STEPS;
    div_num       = {dl, {ptpsrv_pkg::RATIO_FRAC_BITS{1'b0}}};
    div_den       = dm;

    in_stall = (state_r != ptpsrv_pkg::ST_IDLE);

    unique case (state_r)
      ptpsrv_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          ms_nxt    = in_master_stamp[ptpsrv_pkg::STAMP_WIDTH-1:0];
          rx_nxt    = in_local_rx_stamp[ptpsrv_pkg::STAMP_WIDTH-1:0];
          tx_nxt    = in_local_tx_stamp[ptpsrv_pkg::STAMP_WIDTH-1:0];
          state_nxt = ptpsrv_pkg::ST_DECODE;
        end
      end

      ptpsrv_pkg::ST_DECODE: begin
        unique case (cmd_r)
          ptpsrv_pkg::CMD_RATE: begin
            if (!have_first_r) begin
              first_ms_nxt   = ms_r;
              first_rx_nxt   = rx_r;
              have_first_nxt = 1'b1;
              kind_nxt       = ptpsrv_pkg::EV_FIRST;
              state_nxt      = ptpsrv_pkg::ST_DELIVER;
            end else begin
              den_zero_nxt  = (dm == '0);
              div_ctl.start = 1'b1;
              state_nxt     = ptpsrv_pkg::ST_RATIO_DIV;
            end
          end
          ptpsrv_pkg::CMD_SYNC: begin
            origin_nxt = ms_r;
            kind_nxt   = ptpsrv_pkg::EV_ORIGIN;
            state_nxt  = ptpsrv_pkg::ST_DELIVER;
          end
          ptpsrv_pkg::CMD_DELAY: begin
            phase_nxt = 1'b0;
            state_nxt = ptpsrv_pkg::ST_SUM;
          end
          default: begin
            state_nxt = ptpsrv_pkg::ST_IDLE;
          end
        endcase
      end

      ptpsrv_pkg::ST_RATIO_DIV: begin
        if (div_done) begin
          meas_nxt  = ratio_sat ? ptpsrv_pkg::RATIO_MAX : div_quo[ptpsrv_pkg::RATIO_W-1:0];
          state_nxt = ptpsrv_pkg::ST_SMOOTH_PREP;
        end
      end

      ptpsrv_pkg::ST_SMOOTH_PREP: begin
        // |measured - ratio| / 10, sign kept aside: truncates toward zero
        sneg_nxt  = (meas_r < ratio_r);
        meas_nxt  = (meas_r < ratio_r) ? (ratio_r - meas_r) : (meas_r - ratio_r);
        state_nxt = ptpsrv_pkg::ST_SMOOTH_DIV;
      end

      ptpsrv_pkg::ST_SMOOTH_DIV: begin
        ratio_nxt      = sneg_r ? (ratio_r - step) : (ratio_r + step);
        have_first_nxt = 1'b0;
        kind_nxt       = ptpsrv_pkg::EV_RATIO;
        state_nxt      = ptpsrv_pkg::ST_DELIVER;
      end

      ptpsrv_pkg::ST_SUM: begin
        sa_nxt    = {1'b0, op_a} + {1'b0, op_b};
        sb_nxt    = {1'b0, op_c} + {1'b0, op_d};
        state_nxt = ptpsrv_pkg::ST_DIFF;
      end

      ptpsrv_pkg::ST_DIFF: begin
        if (!phase_r) begin
          dly_mag_nxt = diff[ptpsrv_pkg::STAMP_WIDTH:1];
          dly_neg_nxt = ~greater;
          phase_nxt   = 1'b1;
          state_nxt   = ptpsrv_pkg::ST_SUM;
        end else begin
          ofs_mag_nxt = diff[ptpsrv_pkg::STAMP_WIDTH:1];
          ofs_neg_nxt = ~greater;
          kind_nxt    = ptpsrv_pkg::EV_DELAY;
          state_nxt   = ptpsrv_pkg::ST_DELIVER;
        end
      end

      ptpsrv_pkg::ST_DELIVER: begin
        // wait for the output register to be free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = kind_r;
          out_ratio_nxt   = ratio_r;
          out_dly_mag_nxt = dly_mag_r;
          out_dly_neg_nxt = dly_neg_r;
          out_ofs_mag_nxt = ofs_mag_r;
          out_ofs_neg_nxt = ofs_neg_r;
          state_nxt       = ptpsrv_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ptpsrv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ptpsrv_pkg::ST_IDLE;
      first_ms_r   <= '0;
      first_rx_r   <= '0;
      have_first_r <= 1'b0;
      origin_r     <= '0;
      ratio_r      <= ptpsrv_pkg::RATIO_ONE;
      dly_mag_r    <= '0;
      dly_neg_r    <= 1'b0;
      ofs_mag_r    <= '0;
      ofs_neg_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      first_ms_r   <= first_ms_nxt;
      first_rx_r   <= first_rx_nxt;
      have_first_r <= have_first_nxt;
      origin_r     <= origin_nxt;
      ratio_r      <= ratio_nxt;
      dly_mag_r    <= dly_mag_nxt;
      dly_neg_r    <= dly_neg_nxt;
      ofs_mag_r    <= ofs_mag_nxt;
      ofs_neg_r    <= ofs_neg_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cmd_r         <= cmd_nxt;
    ms_r          <= ms_nxt;
    rx_r          <= rx_nxt;
    tx_r          <= tx_nxt;
    den_zero_r    <= den_zero_nxt;
    meas_r        <= meas_nxt;
    sneg_r        <= sneg_nxt;
    phase_r       <= phase_nxt;
    sa_r          <= sa_nxt;
    sb_r          <= sb_nxt;
    kind_r        <= kind_nxt;
    out_kind_r    <= out_kind_nxt;
    out_ratio_r   <= out_ratio_nxt;
    out_dly_mag_r <= out_dly_mag_nxt;
    out_dly_neg_r <= out_dly_neg_nxt;
    out_ofs_mag_r <= out_ofs_mag_nxt;
    out_ofs_neg_r <= out_ofs_neg_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_event_kind       = out_kind_r;
  assign out_freq_ratio       = out_ratio_r;
  assign out_delay_magnitude  = ptpsrv_pkg::IO_STAMP_W'(out_dly_mag_r);
  assign out_delay_negative   = out_dly_neg_r;
  assign out_offset_magnitude = ptpsrv_pkg::IO_STAMP_W'(out_ofs_mag_r);
  assign out_offset_negative  = out_ofs_neg_r;

endmodule

### sim/tb_ptp_delay_offset_rate_servo.sv
// ----------------------------------------------------------------------------
// tb_ptp_delay_offset_rate_servo
// Self-checking bench for the PTP servo: a scoreboard tracks the pair
// state, the smoothed ratio and the held delay/offset, predicts each result
// word and checks it against the block's output, with random idling on both
// channels.
// ----------------------------------------------------------------------------
module tb_ptp_delay_offset_rate_servo;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS   = 800;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 160;
  localparam logic [ptpsrv_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int QUOT_W = ptpsrv_pkg::STAMP_WIDTH + ptpsrv_pkg::RATIO_FRAC_BITS;

  typedef logic [ptpsrv_pkg::IO_STAMP_W-1:0] io_stamp_t;

  typedef struct {
    ptpsrv_pkg::event_kind_t kind;
    ptpsrv_pkg::ratio_t      ratio;
    ptpsrv_pkg::stamp_t      delay_mag;
    logic                    delay_neg;
    ptpsrv_pkg::stamp_t      offset_mag;
    logic                    offset_neg;
  } servo_result_t;

  class servo_scoreboard;
    ptpsrv_pkg::stamp_t pair_master;
    ptpsrv_pkg::stamp_t pair_local;
    bit                 pair_open;
    ptpsrv_pkg::stamp_t origin;
    ptpsrv_pkg::ratio_t ratio;
    ptpsrv_pkg::stamp_t delay_mag;
    bit                 delay_neg;
    ptpsrv_pkg::stamp_t offset_mag;
    bit                 offset_neg;
    servo_result_t      awaited[$];
    int                 mismatches;

    function new();
      pair_master = '0;
      pair_local  = '0;
      pair_open   = 1'b0;
      origin      = '0;
      ratio       = ptpsrv_pkg::RATIO_ONE;
      delay_mag   = '0;
      delay_neg   = 1'b0;
      offset_mag  = '0;
      offset_neg  = 1'b0;
      mismatches  = 0;
    endfunction

    // truncated Q4.F quotient, saturating on zero divisor or no fit in 32 bits
    function ptpsrv_pkg::ratio_t ratio_estimate(ptpsrv_pkg::stamp_t num,
                                                ptpsrv_pkg::stamp_t den);
      logic [QUOT_W-1:0] quot;
      if (den == '0)
        return ptpsrv_pkg::RATIO_MAX;
      quot = {num, {ptpsrv_pkg::RATIO_FRAC_BITS{1'b0}}} / QUOT_W'(den);
      if (quot > QUOT_W'(ptpsrv_pkg::RATIO_MAX))
        return ptpsrv_pkg::RATIO_MAX;
      return ptpsrv_pkg::ratio_t'(quot);
    endfunction

    // half of (a+b)-(c+d) over exact wide sums, as sign and magnitude
    function void half_span(input ptpsrv_pkg::stamp_t a, b, c, d,
                            output ptpsrv_pkg::stamp_t mag, output bit neg);
      ptpsrv_pkg::sum_t lhs, rhs, span;
      lhs  = ptpsrv_pkg::sum_t'(a) + ptpsrv_pkg::sum_t'(b);
      rhs  = ptpsrv_pkg::sum_t'(c) + ptpsrv_pkg::sum_t'(d);
      neg  = !(lhs > rhs);
      span = neg ? rhs - lhs : lhs - rhs;
      mag  = span[ptpsrv_pkg::STAMP_WIDTH:1];
    endfunction

    function void note_word(logic [ptpsrv_pkg::CMD_W-1:0] cmd,
                            io_stamp_t ms_in, rx_in, tx_in);
      servo_result_t      next;
      ptpsrv_pkg::stamp_t ms, rx, tx;
      ptpsrv_pkg::ratio_t measured;
      longint             step;
      ms = ptpsrv_pkg::stamp_t'(ms_in);
      rx = ptpsrv_pkg::stamp_t'(rx_in);
      tx = ptpsrv_pkg::stamp_t'(tx_in);
      case (cmd)
        ptpsrv_pkg::CMD_RATE: begin
          if (!pair_open) begin
            pair_master = ms;
            pair_local  = rx;
            pair_open   = 1'b1;
            next.kind   = ptpsrv_pkg::EV_FIRST;
          end else begin
            measured  = ratio_estimate(rx - pair_local, ms - pair_master);
            // signed division truncates toward zero
            step      = (longint'({32'd0, measured}) - longint'({32'd0, ratio})) / 10;
            ratio     = ptpsrv_pkg::ratio_t'(longint'({32'd0, ratio}) + step);
            pair_open = 1'b0;
            next.kind = ptpsrv_pkg::EV_RATIO;
          end
        end
        ptpsrv_pkg::CMD_SYNC: begin
          origin    = ms;
          next.kind = ptpsrv_pkg::EV_ORIGIN;
        end
        ptpsrv_pkg::CMD_DELAY: begin
          // t4 = master, t2 = rx, t3 = tx, t1 = held origin
          half_span(ms, rx, tx, origin, delay_mag, delay_neg);
          half_span(rx, tx, origin, ms, offset_mag, offset_neg);
          next.kind = ptpsrv_pkg::EV_DELAY;
        end
        default: return;
      endcase
      next.ratio      = ratio;
      next.delay_mag  = delay_mag;
      next.delay_neg  = delay_neg;
      next.offset_mag = offset_mag;
      next.offset_neg = offset_neg;
      awaited.push_back(next);
    endfunction

    function void compare_field(string label, logic [63:0] want, logic [63:0] seen);
      if (seen !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, seen);
      end
    endfunction

    function void check_word(servo_result_t got);
      servo_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none, actual kind %0d ratio %h",
                 $time, got.kind, got.ratio);
        return;
      end
      want = awaited.pop_front();
      compare_field("event_kind", 64'(want.kind), 64'(got.kind));
      compare_field("freq_ratio", 64'(want.ratio), 64'(got.ratio));
      compare_field("delay_magnitude", want.delay_mag, got.delay_mag);
      compare_field("delay_negative", 64'(want.delay_neg), 64'(got.delay_neg));
      compare_field("offset_magnitude", want.offset_mag, got.offset_mag);
      compare_field("offset_negative", 64'(want.offset_neg), 64'(got.offset_neg));
    endfunction

    function int awaiting();
      return awaited.size();
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [ptpsrv_pkg::CMD_W-1:0]      in_command;
  io_stamp_t                         in_master_stamp;
  io_stamp_t                         in_local_rx_stamp;
  io_stamp_t                         in_local_tx_stamp;
  logic                              out_valid;
  logic                              out_stall;
  logic [1:0]                        out_event_kind;
  logic [ptpsrv_pkg::RATIO_W-1:0]    out_freq_ratio;
  io_stamp_t                         out_delay_magnitude;
  logic                              out_delay_negative;
  io_stamp_t                         out_offset_magnitude;
  logic                              out_offset_negative;

  servo_scoreboard tracker;
  bit              in_no_idle  = 1'b0;
  bit              out_no_idle = 1'b0;
  int              idle_cycles = 0;

  ptp_delay_offset_rate_servo dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_master_stamp      (in_master_stamp),
    .in_local_rx_stamp    (in_local_rx_stamp),
    .in_local_tx_stamp    (in_local_tx_stamp),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_event_kind       (out_event_kind),
    .out_freq_ratio       (out_freq_ratio),
    .out_delay_magnitude  (out_delay_magnitude),
    .out_delay_negative   (out_delay_negative),
    .out_offset_magnitude (out_offset_magnitude),
    .out_offset_negative  (out_offset_negative)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic io_stamp_t rand_stamp();
    return {$urandom, $urandom};
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic [ptpsrv_pkg::CMD_W-1:0] cmd,
                           input io_stamp_t ms, rx, tx);
    int gap;
    gap = in_no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_master_stamp   <= ms;
    in_local_rx_stamp <= rx;
    in_local_tx_stamp <= tx;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_word(cmd, ms, rx, tx);
    @(negedge clk);
  endtask

  task automatic send_rate(input io_stamp_t ms, rx);
    send_word(ptpsrv_pkg::CMD_RATE, ms, rx, rand_stamp());
  endtask

  // receive side
  initial begin
    int            hold;
    servo_result_t got;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      hold = out_no_idle ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.kind       = ptpsrv_pkg::event_kind_t'(out_event_kind);
      got.ratio      = out_freq_ratio;
      got.delay_mag  = out_delay_magnitude;
      got.delay_neg  = out_delay_negative;
      got.offset_mag = out_offset_magnitude;
      got.offset_neg = out_offset_negative;
      tracker.check_word(got);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int        words;
    io_stamp_t m1, l1, dm, dl, t1, t2, t3, t4, slip, skew;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_command        = ptpsrv_pkg::CMD_RATE;
    in_master_stamp   = '0;
    in_local_rx_stamp = '0;
    in_local_tx_stamp = '0;
    tracker           = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: delay before any sync uses the zero origin
    send_word(ptpsrv_pkg::CMD_DELAY, 64'd100, 64'd50, 64'd20);
    send_word(CMD_UNUSED, rand_stamp(), rand_stamp(), rand_stamp());
    // zero master difference saturates
    send_rate(64'd0, 64'd0);
    send_rate(64'd0, 64'd5);
    // overflowing ratio, with an ignored word inside the pair
    send_rate(64'd1000, 64'd0);
    send_word(CMD_UNUSED, '1, '1, '1);
    send_rate(64'd1001, 64'h0000_0100_0000_0000);
    // both stamps wrap between the pair
    send_rate(64'hFFFF_FFFF_FFFF_FFF5, 64'hFFFF_FFFF_FFFF_FFEB);
    send_rate(64'd5, 64'd100);
    // unity, then zero local difference
    send_rate(64'd0, 64'd7);
    send_rate(64'd1_000_000_000, 64'd1_000_000_007);
    send_rate(64'd50, 64'd60);
    send_rate(64'd90, 64'd60);
    // tiny ratio from huge master difference
    send_rate(64'd0, '1);
    send_rate('1, 64'd2);
    // extreme stamps; equal sums on both
    send_word(ptpsrv_pkg::CMD_SYNC, '1, '0, '0);
    send_word(ptpsrv_pkg::CMD_DELAY, '1, '1, '1);
    send_word(ptpsrv_pkg::CMD_SYNC, '0, '1, '1);
    send_word(ptpsrv_pkg::CMD_DELAY, '1, '1, '0);
    send_word(ptpsrv_pkg::CMD_DELAY, '0, '0, '1);
    // odd differences truncate; negative with zero magnitude
    send_word(ptpsrv_pkg::CMD_SYNC, 64'd1000, '0, '0);
    send_word(ptpsrv_pkg::CMD_DELAY, 64'd1300, 64'd1100, 64'd1200);
    send_word(ptpsrv_pkg::CMD_DELAY, 64'd1301, 64'd1100, 64'd1200);

    words = 0;
    while (words < RANDOM_WORDS) begin
      if ($urandom_range(0, 15) == 0)
        in_no_idle = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 15) == 0)
        out_no_idle = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          // well-formed rate pair
          m1 = rand_stamp();
          l1 = rand_stamp();
          dm = rand_stamp() >> $urandom_range(0, 63);
          case ($urandom_range(0, 3))
            0, 1: begin
              slip = dm >> $urandom_range(3, 40);
              dl   = $urandom_range(0, 1) ? dm + slip : dm - slip;
            end
            2:       dl = rand_stamp() >> $urandom_range(0, 63);
            default: dl = dm * $urandom_range(0, 17);
          endcase
          send_rate(m1, l1);
          send_rate(m1 + dm, l1 + dl);
          words += 2;
        end
        8, 9, 10, 11, 12, 13: begin
          // sync then one or two consistent delay responses
          t1   = rand_stamp();
          dl   = $urandom_range(0, 1 << 20);
          skew = $urandom_range(0, 1 << 30);
          t2   = $urandom_range(0, 1) ? t1 + dl + skew : t1 + dl - skew;
          t3   = t2 + $urandom_range(0, 1 << 16);
          t4   = (t2 > t1 + dl) ? t3 + dl - skew : t3 + dl + skew;
          send_word(ptpsrv_pkg::CMD_SYNC, t1, rand_stamp(), rand_stamp());
          send_word(ptpsrv_pkg::CMD_DELAY, t4, t2, t3);
          words += 2;
          if ($urandom_range(0, 3) == 0) begin
            send_word(ptpsrv_pkg::CMD_DELAY, t4 + $urandom_range(0, 255), t2, t3);
            words++;
          end
        end
        14, 15: begin
          send_rate(rand_stamp(), rand_stamp());
          words++;
        end
        16, 17: begin
          send_word($urandom_range(0, 1) ? ptpsrv_pkg::CMD_SYNC : ptpsrv_pkg::CMD_DELAY,
                    rand_stamp(), rand_stamp(), rand_stamp());
          words++;
        end
        default: send_word(CMD_UNUSED, rand_stamp(), rand_stamp(), rand_stamp());
      endcase
    end
    in_valid <= 1'b0;

    while (tracker.awaiting() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaiting() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
